FILE: sv/uds_sa_pkg.sv
package uds_sa_pkg;

  localparam int UDS_NUM_LEVELS = 4;
  localparam int MAX_LEVELS     = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_LEVEL_ENABLE  = 3'd0;
  localparam logic [2:0] REG_KEY_LENGTH    = 3'd1;
  localparam logic [2:0] REG_FAIL_LIMIT    = 3'd2;
  localparam logic [2:0] REG_RELOCK_DELAY  = 3'd3;
  localparam logic [2:0] REG_SESSION_CHECK = 3'd4;
  localparam logic [2:0] REG_SESSION_MASKS = 3'd5;

  localparam logic [3:0]  RST_LEVEL_ENABLE  = 4'hF;
  localparam logic [7:0]  RST_KEY_LENGTH    = 8'd4;
  localparam logic [7:0]  RST_FAIL_LIMIT    = 8'd3;
  localparam logic [31:0] RST_RELOCK_DELAY  = 32'd10000;
  localparam logic        RST_SESSION_CHECK = 1'b0;
  localparam logic [31:0] RST_SESSION_MASKS = 32'hFFFF_FFFF;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef enum logic [3:0] {
    RSP_OK           = 4'd0,
    RSP_BAD_LENGTH   = 4'd1,
    RSP_UNSUPPORTED  = 4'd2,
    RSP_OUT_OF_RANGE = 4'd3,
    RSP_WRONG_SESS   = 4'd4,
    RSP_REJECT       = 4'd5,
    RSP_INVALID_KEY  = 4'd6,
    RSP_EXCEEDED     = 4'd7,
    RSP_DELAY        = 4'd8,
    RSP_SEQUENCE     = 4'd9
  } rsp_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_STORED = 2'd1,
    ACT_ZERO   = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    G_OFF  = 3'b001,
    G_ON   = 3'b010,
    G_LOCK = 3'b100
  } glob_t;

  typedef enum logic [2:0] {
    L_OFF  = 3'b001,
    L_ON   = 3'b010,
    L_WAIT = 3'b100
  } lvl_t;

  typedef struct packed {
    logic [3:0]  level_enable_mask;
    logic [7:0]  key_length;
    logic [7:0]  fail_limit;
    logic [31:0] relock_delay;
    logic        session_check_on;
    logic [31:0] session_masks;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  sub_function;
    logic [11:0] message_length;
    logic [7:0]  session_bits;
    logic        seed_ready;
    logic        key_ready;
    logic        key_matches;
    logic [15:0] elapsed_ticks;
  } item_t;

  typedef struct packed {
    rsp_t       code;
    act_t       act;
    logic [2:0] level;
    logic       locked;
    logic [7:0] fails;
  } res_t;

endpackage

FILE: sv/uds_sa_cfg.sv
module uds_sa_cfg import uds_sa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_enable_mask <= RST_LEVEL_ENABLE;
      cfg.key_length        <= RST_KEY_LENGTH;
      cfg.fail_limit        <= RST_FAIL_LIMIT;
      cfg.relock_delay      <= RST_RELOCK_DELAY;
      cfg.session_check_on  <= RST_SESSION_CHECK;
      cfg.session_masks     <= RST_SESSION_MASKS;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_LEVEL_ENABLE:  cfg.level_enable_mask <= cfg_data[3:0];
        REG_KEY_LENGTH:    cfg.key_length        <= cfg_data[7:0];
        REG_FAIL_LIMIT:    cfg.fail_limit        <= cfg_data[7:0];
        REG_RELOCK_DELAY:  cfg.relock_delay      <= cfg_data;
        REG_SESSION_CHECK: cfg.session_check_on  <= cfg_data[0];
        REG_SESSION_MASKS: cfg.session_masks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/uds_sa_core.sv
module uds_sa_core import uds_sa_pkg::*; #(
  parameter int NUM_LEVELS = UDS_NUM_LEVELS
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  glob_t       gstat, gstat_next;
  lvl_t        lvl [NUM_LEVELS];
  lvl_t        lvl_next [NUM_LEVELS];
  logic        held [NUM_LEVELS];
  logic        held_next [NUM_LEVELS];
  logic [7:0]  fails, fails_next;
  logic [8:0]  run, run_next;
  logic [31:0] elapsed, elapsed_next;
  logic [2:0]  active, active_next;

  logic [7:0]  sf_m1;
  logic [1:0]  idx;
  logic        seed_req;
  logic        sf_bad;
  logic        len_bad;
  lvl_t        lvl_cur;
  logic        held_cur;
  logic        held_new;
  logic [32:0] tick_sum;
  logic [31:0] tick_sat;
  logic [8:0]  run_cap;
  logic [11:0] key_len_total;
  logic [7:0]  sess_mask;
  logic        do_fail;
  logic        fail_seed;
  rsp_t        code;
  act_t        act;

  assign sf_m1         = item.sub_function - 8'd1;
  assign idx           = sf_m1[2:1];
  assign seed_req      = item.sub_function[0];
  assign sf_bad        = (item.sub_function < 8'd1) || (item.sub_function > 8'd8) ||
                         (32'(idx) >= NUM_LEVELS) || !cfg.level_enable_mask[idx];
  assign key_len_total = {4'd0, cfg.key_length} + 12'd2;
  assign len_bad       = seed_req ? (item.message_length != 12'd2)
                                  : (item.message_length != key_len_total);
  assign run_cap       = {1'b0, cfg.fail_limit} + 9'd1;
  assign sess_mask     = cfg.session_masks[{idx, 3'b000} +: 8];
  assign tick_sum      = {1'b0, elapsed} + {17'd0, item.elapsed_ticks};
  assign tick_sat      = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];

  always_comb begin
    lvl_cur  = L_OFF;
    held_cur = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (idx == 2'(i)) begin
        lvl_cur  = lvl[i];
        held_cur = held[i];
      end
    end
  end

  assign held_new = held_cur | item.seed_ready;

  always_comb begin
    gstat_next   = gstat;
    lvl_next     = lvl;
    held_next    = held;
    fails_next   = fails;
    run_next     = run;
    elapsed_next = elapsed;
    active_next  = active;
    code         = RSP_OK;
    act          = ACT_NONE;
    do_fail      = 1'b0;
    fail_seed    = 1'b0;

    if (item.operation == OP_TICK) begin
      // timer only runs while locked
      if (gstat == G_LOCK) begin
        elapsed_next = tick_sat;
        if (tick_sat >= cfg.relock_delay) begin
          gstat_next   = G_OFF;
          elapsed_next = 32'd0;
          active_next  = 3'd0;
          for (int i = 0; i < NUM_LEVELS; i++) begin
            lvl_next[i]  = L_OFF;
            held_next[i] = 1'b0;
          end
          if (cfg.fail_limit != 8'd0 && fails != 8'd0) begin
            fails_next = fails - 8'd1;
            run_next   = 9'd0;
          end
        end
      end
    end else if (item.message_length < 12'd2) begin
      code = RSP_BAD_LENGTH;
    end else if (sf_bad) begin
      code = RSP_UNSUPPORTED;
    end else if (len_bad) begin
      code = RSP_BAD_LENGTH;
    end else begin
      case (gstat)
        G_LOCK: code = seed_req ? RSP_DELAY : RSP_SEQUENCE;
        G_OFF, G_ON: begin
          if (seed_req) begin
            if (gstat == G_ON && lvl_cur == L_ON) begin
              act = ACT_ZERO;
            end else begin
              do_fail   = 1'b1;
              fail_seed = 1'b1;
            end
          end else if (lvl_cur == L_WAIT) begin
            if (!item.key_ready) begin
              code = RSP_REJECT;
            end else if (!item.key_matches) begin
              do_fail = 1'b1;
            end else begin
              gstat_next   = G_ON;
              fails_next   = 8'd0;
              run_next     = 9'd0;
              elapsed_next = 32'd0;
              active_next  = {1'b0, idx} + 3'd1;
              for (int i = 0; i < NUM_LEVELS; i++) begin
                lvl_next[i] = (idx == 2'(i)) ? L_ON : L_OFF;
              end
            end
          end else begin
            code = RSP_SEQUENCE;
          end
        end
        default: code = RSP_UNSUPPORTED;
      endcase
    end

    if (do_fail) begin
      // repeated seed requests count from the second one on
      if (fail_seed) begin
        if (run != 9'h1FF) begin
          run_next = run + 9'd1;
        end
        if (run_next >= 9'd2 && fails != 8'hFF) begin
          fails_next = fails + 8'd1;
        end
        if (run_next >= run_cap) begin
          run_next = run_cap;
        end
      end else begin
        run_next = 9'd0;
        if (fails != 8'hFF) begin
          fails_next = fails + 8'd1;
        end
      end

      if (fails_next >= cfg.fail_limit) begin
        fails_next  = cfg.fail_limit;
        gstat_next  = G_LOCK;
        active_next = 3'd0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
          lvl_next[i]  = L_OFF;
          held_next[i] = 1'b0;
        end
        code = RSP_EXCEEDED;
      end else if (!fail_seed) begin
        code = RSP_INVALID_KEY;
      end else if (cfg.session_check_on && (item.session_bits & sess_mask) == 8'd0) begin
        code = RSP_WRONG_SESS;
      end else begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (idx == 2'(i)) begin
            held_next[i] = held_new;
            if (held_new) begin
              lvl_next[i] = L_WAIT;
            end
          end
        end
        if (!held_new) begin
          code = RSP_REJECT;
        end else begin
          act = ACT_STORED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gstat   <= G_OFF;
      fails   <= 8'd0;
      run     <= 9'd0;
      elapsed <= 32'd0;
      active  <= 3'd0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        lvl[i]  <= L_OFF;
        held[i] <= 1'b0;
      end
    end else if (en) begin
      gstat   <= gstat_next;
      fails   <= fails_next;
      run     <= run_next;
      elapsed <= elapsed_next;
      active  <= active_next;
      lvl     <= lvl_next;
      held    <= held_next;
    end
  end

  assign res.code   = code;
  assign res.act    = act;
  assign res.level  = active_next;
  assign res.locked = (gstat_next == G_LOCK);
  assign res.fails  = fails_next;

endmodule

FILE: sv/uds_security_access_lockout.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------------
// in       | in_valid/in_stall  | operation, sub_function, message_length, ...
// out      | out_valid/out_stall| response_code, seed_action, unlocked_level, ...
// cfg      | cfg_write_en       | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; a result passes through the input
// register, then the state update into the result register.
// Synchronous active-high reset returns configuration, state and valid flags to defaults.
// A stalled result holds the input register, which then stalls the input.
module uds_security_access_lockout import uds_sa_pkg::*; #(
  parameter int NUM_LEVELS = UDS_NUM_LEVELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  sub_function,
  input  logic [11:0] message_length,
  input  logic [7:0]  session_bits,
  input  logic        seed_ready,
  input  logic        key_ready,
  input  logic        key_matches,
  input  logic [15:0] elapsed_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  response_code,
  output logic [1:0]  seed_action,
  output logic [2:0]  unlocked_level,
  output logic        is_locked,
  output logic [7:0]  fail_count
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  advance;
  logic  in_xfer;
  res_t  res_comb;
  res_t  res;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  uds_sa_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  uds_sa_core #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (item),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_xfer) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item.operation      <= operation;
      item.sub_function   <= sub_function;
      item.message_length <= message_length;
      item.session_bits   <= session_bits;
      item.seed_ready     <= seed_ready;
      item.key_ready      <= key_ready;
      item.key_matches    <= key_matches;
      item.elapsed_ticks  <= elapsed_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign response_code  = res.code;
  assign seed_action    = res.act;
  assign unlocked_level = res.level;
  assign is_locked      = res.locked;
  assign fail_count     = res.fails;

endmodule

FILE: tb/access_gate_check.sv
`timescale 1ns / 100ps

module access_gate_check import uds_sa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  sub_function,
  input  logic [11:0] message_length,
  input  logic [7:0]  session_bits,
  input  logic        seed_ready,
  input  logic        key_ready,
  input  logic        key_matches,
  input  logic [15:0] elapsed_ticks,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  response_code,
  input  logic [1:0]  seed_action,
  input  logic [2:0]  unlocked_level,
  input  logic        is_locked,
  input  logic [7:0]  fail_count,
  output int          mismatches,
  output int          pending,
  output int          compared,
  output int          lockouts
);

  // register copy and gate state
  cfg_t        regs;
  glob_t       gate;
  logic        hold;
  lvl_t        lvl_state [MAX_LEVELS];
  logic        seed_kept [MAX_LEVELS];
  logic [7:0]  fails;
  logic [8:0]  seed_run;
  logic [31:0] lock_time;
  logic [2:0]  active;

  res_t  expected_responses [$];
  item_t request;
  res_t  want;
  int    errors = 0;
  int    checked = 0;
  int    locks = 0;

  initial begin
    mismatches = 0;
    pending = 0;
    compared = 0;
    lockouts = 0;
  end

  task automatic report(input string msg);
    if (errors < 100) $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic void drop_levels();
    for (int i = 0; i < MAX_LEVELS; i++) begin
      lvl_state[i] = L_OFF;
      seed_kept[i] = 1'b0;
    end
    active = 3'd0;
  endfunction

  function automatic void move_gate(input glob_t s);
    // an active lock holds until the timer releases it
    if (hold && gate == G_LOCK) return;
    if (s == G_LOCK) begin
      hold = 1'b1;
      drop_levels();
      locks++;
    end else if (s == G_OFF) begin
      drop_levels();
    end else begin
      fails = 8'd0;
      seed_run = 9'd0;
      lock_time = 32'd0;
    end
    gate = s;
  endfunction

  function automatic rsp_t note_failure(input logic seed_req);
    if (seed_req) begin
      if (seed_run < 9'd511) seed_run = seed_run + 9'd1;
      if (seed_run >= 9'd2 && fails < 8'd255) fails = fails + 8'd1;
      if (seed_run >= {1'b0, regs.fail_limit} + 9'd1)
        seed_run = {1'b0, regs.fail_limit} + 9'd1;
    end else begin
      seed_run = 9'd0;
      if (fails < 8'd255) fails = fails + 8'd1;
    end
    if (fails >= regs.fail_limit) begin
      fails = regs.fail_limit;
      move_gate(G_LOCK);
      return RSP_EXCEEDED;
    end
    return RSP_INVALID_KEY;
  endfunction

  function automatic rsp_t hand_out_seed(input int idx, input logic [7:0] sess,
                                         input logic ready, output act_t act);
    act = ACT_NONE;
    if (note_failure(1'b1) == RSP_EXCEEDED) return RSP_EXCEEDED;
    if (regs.session_check_on && (sess & regs.session_masks[8*idx +: 8]) == 8'd0)
      return RSP_WRONG_SESS;
    if (!seed_kept[idx] && ready) seed_kept[idx] = 1'b1;
    if (!seed_kept[idx]) return RSP_REJECT;
    lvl_state[idx] = L_WAIT;
    act = ACT_STORED;
    return RSP_OK;
  endfunction

  function automatic rsp_t verify_key(input int idx, input logic kready,
                                      input logic kmatch);
    if (!kready) return RSP_REJECT;
    if (!kmatch) return note_failure(1'b0);
    move_gate(G_ON);
    for (int i = 0; i < MAX_LEVELS; i++) lvl_state[i] = (i == idx) ? L_ON : L_OFF;
    active = 3'(idx + 1);
    return RSP_OK;
  endfunction

  function automatic res_t predict_response(input item_t it);
    res_t        r;
    int          idx;
    logic        seed_req;
    logic [11:0] want_len;
    r.code = RSP_OK;
    r.act = ACT_NONE;
    if (it.operation == OP_TICK) begin
      if (gate == G_LOCK) begin
        // saturate the lock timer
        if (lock_time > 32'hFFFF_FFFF - {16'd0, it.elapsed_ticks}) lock_time = '1;
        else lock_time = lock_time + {16'd0, it.elapsed_ticks};
        if (lock_time >= regs.relock_delay) begin
          hold = 1'b0;
          move_gate(G_OFF);
          lock_time = 32'd0;
          if (regs.fail_limit != 8'd0 && fails != 8'd0) begin
            fails = fails - 8'd1;
            seed_run = 9'd0;
          end
        end
      end
    end else if (it.message_length < 12'd2) begin
      r.code = RSP_BAD_LENGTH;
    end else if (it.sub_function == 8'd0 || it.sub_function > 8'd8) begin
      r.code = RSP_UNSUPPORTED;
    end else begin
      idx = (int'(it.sub_function) - 1) / 2;
      seed_req = it.sub_function[0];
      want_len = seed_req ? 12'd2 : {4'd0, regs.key_length} + 12'd2;
      if (idx >= UDS_NUM_LEVELS || !regs.level_enable_mask[idx]) begin
        r.code = RSP_UNSUPPORTED;
      end else if (it.message_length != want_len) begin
        r.code = RSP_BAD_LENGTH;
      end else if (gate == G_LOCK) begin
        r.code = seed_req ? RSP_DELAY : RSP_SEQUENCE;
      end else if (seed_req) begin
        if (gate == G_ON && lvl_state[idx] == L_ON) r.act = ACT_ZERO;
        else r.code = hand_out_seed(idx, it.session_bits, it.seed_ready, r.act);
      end else if (lvl_state[idx] == L_WAIT) begin
        r.code = verify_key(idx, it.key_ready, it.key_matches);
      end else begin
        r.code = RSP_SEQUENCE;
      end
    end
    r.level = active;
    r.locked = (gate == G_LOCK);
    r.fails = fails;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.level_enable_mask = RST_LEVEL_ENABLE;
      regs.key_length = RST_KEY_LENGTH;
      regs.fail_limit = RST_FAIL_LIMIT;
      regs.relock_delay = RST_RELOCK_DELAY;
      regs.session_check_on = RST_SESSION_CHECK;
      regs.session_masks = RST_SESSION_MASKS;
      gate = G_OFF;
      hold = 1'b0;
      drop_levels();
      fails = 8'd0;
      seed_run = 9'd0;
      lock_time = 32'd0;
      expected_responses.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          report($sformatf("result with nothing expected (response_code %0d)",
                           response_code));
        end else begin
          want = expected_responses.pop_front();
          checked++;
          if (response_code !== want.code)
            report($sformatf("response_code got %0d want %0d", response_code, want.code));
          if (seed_action !== want.act)
            report($sformatf("seed_action got %0d want %0d", seed_action, want.act));
          if (unlocked_level !== want.level)
            report($sformatf("unlocked_level got %0d want %0d", unlocked_level,
                             want.level));
          if (is_locked !== want.locked)
            report($sformatf("is_locked got %0d want %0d", is_locked, want.locked));
          if (fail_count !== want.fails)
            report($sformatf("fail_count got %0d want %0d", fail_count, want.fails));
        end
      end
      if (cfg_write_en) begin
        case (cfg_index)
          REG_LEVEL_ENABLE:  regs.level_enable_mask = cfg_data[3:0];
          REG_KEY_LENGTH:    regs.key_length = cfg_data[7:0];
          REG_FAIL_LIMIT:    regs.fail_limit = cfg_data[7:0];
          REG_RELOCK_DELAY:  regs.relock_delay = cfg_data;
          REG_SESSION_CHECK: regs.session_check_on = cfg_data[0];
          REG_SESSION_MASKS: regs.session_masks = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        request.operation = operation;
        request.sub_function = sub_function;
        request.message_length = message_length;
        request.session_bits = session_bits;
        request.seed_ready = seed_ready;
        request.key_ready = key_ready;
        request.key_matches = key_matches;
        request.elapsed_ticks = elapsed_ticks;
        expected_responses.push_back(predict_response(request));
      end
    end
    pending <= expected_responses.size();
    mismatches <= errors;
    compared <= checked;
    lockouts <= locks;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import uds_sa_pkg::*;

  localparam int CYCLE_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [7:0]  sub_function = '0;
  logic [11:0] message_length = '0;
  logic [7:0]  session_bits = '0;
  logic        seed_ready = 1'b0;
  logic        key_ready = 1'b0;
  logic        key_matches = 1'b0;
  logic [15:0] elapsed_ticks = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  response_code;
  logic [1:0]  seed_action;
  logic [2:0]  unlocked_level;
  logic        is_locked;
  logic [7:0]  fail_count;

  int mismatches, pending, compared, lockouts;
  int sent = 0;
  int phases = 0;
  int cycles = 0;
  int squeeze_left = 0;
  logic sender_calm = 1'b0;
  logic receiver_calm = 1'b0;
  logic squeeze_req = 1'b0;
  logic squeeze_done = 1'b0;
  cfg_t setting;

  always #5 clk = ~clk;

  uds_security_access_lockout dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .sub_function(sub_function), .message_length(message_length),
    .session_bits(session_bits), .seed_ready(seed_ready), .key_ready(key_ready),
    .key_matches(key_matches), .elapsed_ticks(elapsed_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .response_code(response_code), .seed_action(seed_action),
    .unlocked_level(unlocked_level), .is_locked(is_locked), .fail_count(fail_count)
  );

  access_gate_check gate_check (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .sub_function(sub_function), .message_length(message_length),
    .session_bits(session_bits), .seed_ready(seed_ready), .key_ready(key_ready),
    .key_matches(key_matches), .elapsed_ticks(elapsed_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .response_code(response_code), .seed_action(seed_action),
    .unlocked_level(unlocked_level), .is_locked(is_locked), .fail_count(fail_count),
    .mismatches(mismatches), .pending(pending), .compared(compared), .lockouts(lockouts)
  );

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (squeeze_left != 0) begin
      out_stall <= 1'b1;
      squeeze_left <= squeeze_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_stall <= 1'b1;
      squeeze_left <= 80;
      squeeze_done <= 1'b1;
    end else begin
      out_stall <= !receiver_calm && ($urandom_range(99) < 27);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic item_t make_req(input logic [7:0] sf, input logic [11:0] len,
                                     input logic [7:0] sess, input logic sr,
                                     input logic kr, input logic km);
    item_t it;
    it.operation = OP_REQUEST;
    it.sub_function = sf;
    it.message_length = len;
    it.session_bits = sess;
    it.seed_ready = sr;
    it.key_ready = kr;
    it.key_matches = km;
    it.elapsed_ticks = 16'($urandom);
    return it;
  endfunction

  function automatic item_t make_tick(input logic [15:0] ticks);
    item_t it;
    it = make_req(8'($urandom), 12'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom), 1'($urandom));
    it.operation = OP_TICK;
    it.elapsed_ticks = ticks;
    return it;
  endfunction

  task automatic offer(input item_t it);
    if (!sender_calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 27);
    end
    in_valid <= 1'b1;
    operation <= it.operation;
    sub_function <= it.sub_function;
    message_length <= it.message_length;
    session_bits <= it.session_bits;
    seed_ready <= it.seed_ready;
    key_ready <= it.key_ready;
    key_matches <= it.key_matches;
    elapsed_ticks <= it.elapsed_ticks;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // drop valid and wait for every outstanding response
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    put_reg(REG_LEVEL_ENABLE, {28'd0, c.level_enable_mask});
    put_reg(REG_KEY_LENGTH, {24'd0, c.key_length});
    put_reg(REG_FAIL_LIMIT, {24'd0, c.fail_limit});
    put_reg(REG_RELOCK_DELAY, c.relock_delay);
    put_reg(REG_SESSION_CHECK, {31'd0, c.session_check_on});
    put_reg(REG_SESSION_MASKS, c.session_masks);
    cfg_write_en <= 1'b0;
    setting = c;
    phases++;
  endtask

  function automatic cfg_t pick_setting(input int p);
    cfg_t c;
    c.level_enable_mask = 4'hF;
    c.key_length = 8'd4;
    c.fail_limit = 8'd3;
    c.relock_delay = 32'd500;
    c.session_check_on = 1'b0;
    c.session_masks = '1;
    case (p)
      0: ;
      1: begin
        c.level_enable_mask = 4'h0;
        c.key_length = 8'd1;
        c.fail_limit = 8'd0;
        c.relock_delay = 32'd0;
        c.session_check_on = 1'b1;
        c.session_masks = 32'd0;
      end
      2: begin
        c.level_enable_mask = 4'($urandom_range(15, 1));
        c.key_length = 8'd255;
        c.fail_limit = 8'd255;
        c.relock_delay = '1;
        c.session_check_on = 1'b1;
        c.session_masks = $urandom;
      end
      3: begin
        c.key_length = 8'($urandom_range(255, 1));
        c.fail_limit = 8'd1;
        c.relock_delay = 32'd0;
      end
      4: begin
        c.key_length = 8'($urandom_range(16, 1));
        c.fail_limit = 8'($urandom_range(6, 2));
        c.relock_delay = $urandom_range(3000);
        c.session_check_on = 1'b1;
        c.session_masks = $urandom;
      end
      // long lock: first failure locks, delay spans many full ticks
      8: begin
        c.fail_limit = 8'd0;
        c.relock_delay = 32'd1000000;
      end
      default: begin
        c.level_enable_mask = 4'($urandom);
        c.key_length = 8'($urandom_range(255, 1));
        c.fail_limit = 8'($urandom_range(8));
        c.relock_delay = $urandom_range(100000);
        c.session_check_on = 1'($urandom);
        c.session_masks = $urandom;
      end
    endcase
    return c;
  endfunction

  // mostly seed/key pairs with random content, some ticks and noise
  task automatic random_traffic(input int n);
    int         k;
    int         roll;
    int         lv;
    logic [7:0] sess;
    item_t      junk;
    k = 0;
    while (k < n) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        offer(make_tick(($urandom_range(99) < 50) ? 16'($urandom)
                                                  : 16'($urandom_range(400))));
        k++;
      end else if (roll < 22) begin
        junk = make_req(8'($urandom), ($urandom_range(99) < 50) ? 12'($urandom)
                                                                : 12'($urandom_range(12)),
                        8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        offer(junk);
        k++;
      end else begin
        lv = $urandom_range(3);
        sess = ($urandom_range(99) < 80) ? 8'(1 << $urandom_range(7)) : 8'($urandom);
        offer(make_req(8'(2 * lv + 1),
                       ($urandom_range(99) < 95) ? 12'd2 : 12'($urandom),
                       sess, $urandom_range(99) < 85, 1'($urandom), 1'($urandom)));
        k++;
        if ($urandom_range(99) < 80) begin
          offer(make_req(8'(2 * lv + 2),
                         ($urandom_range(99) < 95) ? {4'd0, setting.key_length} + 12'd2
                                                   : 12'($urandom),
                         sess, 1'($urandom), $urandom_range(99) < 90,
                         $urandom_range(99) < 55));
          k++;
        end
      end
    end
  endtask

  initial begin
    setting = pick_setting(0);
    setting.relock_delay = RST_RELOCK_DELAY;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed walk through the gate with reset register values
    offer(make_tick(16'd0));
    offer(make_req(8'd1, 12'd0, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'hFF, 12'd1, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd0, 12'd2, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd9, 12'd2, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'hFF, 12'hFFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd1, 12'd3, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd2, 12'd6, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd1, 12'd2, 8'h01, 1'b0, 1'b1, 1'b1));
    offer(make_req(8'd1, 12'd2, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd2, 12'd6, 8'h01, 1'b1, 1'b0, 1'b1));
    offer(make_req(8'd2, 12'd6, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd1, 12'd2, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd3, 12'd2, 8'h02, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd4, 12'd6, 8'h02, 1'b1, 1'b1, 1'b0));
    offer(make_req(8'd3, 12'd2, 8'h02, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd4, 12'd6, 8'h02, 1'b1, 1'b1, 1'b0));
    offer(make_req(8'd5, 12'd2, 8'h04, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd6, 12'd6, 8'h04, 1'b1, 1'b1, 1'b0));
    offer(make_req(8'd7, 12'd2, 8'h08, 1'b1, 1'b1, 1'b1));
    offer(make_req(8'd8, 12'd6, 8'h08, 1'b1, 1'b1, 1'b1));
    offer(make_tick(16'd9999));
    offer(make_tick(16'hFFFF));
    offer(make_req(8'd7, 12'd2, 8'h80, 1'b1, 1'b1, 1'b1));

    for (int p = 0; p < 8; p++) begin
      settle();
      sender_calm = (p == 4);
      receiver_calm <= (p == 4);
      load_config(pick_setting(p));
      if (p == 0) squeeze_req <= 1'b1;
      random_traffic((p == 1) ? 60 : 255);
    end

    // hold the lock across a run of full ticks until the long delay expires
    settle();
    sender_calm = 1'b1;
    receiver_calm <= 1'b0;
    load_config(pick_setting(8));
    offer(make_req(8'd1, 12'd2, 8'h01, 1'b1, 1'b1, 1'b1));
    offer(make_tick(16'd100));
    for (int k = 0; k < 20; k++) begin
      if (k == 10) offer(make_req(8'd3, 12'd2, 8'h01, 1'b1, 1'b1, 1'b1));
      offer(make_tick(16'hFFFF));
    end
    offer(make_req(8'd1, 12'd2, 8'h01, 1'b1, 1'b1, 1'b1));

    settle();
    repeat (4) @(posedge clk);
    $display("%0d items over %0d register settings, %0d responses compared",
             sent, phases, compared);
    $display("gate locked %0d times, one lock held across a run of full-width ticks",
             lockouts);
    if (mismatches == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: uds_security_access_lockout.f
sv/uds_sa_pkg.sv
sv/uds_sa_cfg.sv
sv/uds_sa_core.sv
sv/uds_security_access_lockout.sv
tb/access_gate_check.sv
tb/testbench.sv
